[rtl/disc_pair_collision_resolve_core_assert.svh]
// Assertion macros for the disc pair collision core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DISC_PAIR_COLLISION_RESOLVE_CORE_ASSERT_SVH
`define DISC_PAIR_COLLISION_RESOLVE_CORE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define DPCR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// post must hold in the cycle after pre
`define DPCR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/dpcr_pkg.sv]
// Shared widths, reset values, register indexes and types for the disc pair collision core.
// No dependencies; imported by the divider and the top level.
package dpcr_pkg;

	// field widths
	localparam int POS_W   = 20;
	localparam int VEL_W   = 16;
	localparam int RAD_W   = 16;
	localparam int DATA_W  = 144;

	// datapath widths
	localparam int MAG_W   = 20;   // |dx|, |dy| and multiplier operands
	localparam int DVM_W   = 16;   // |dvx|, |dvy|
	localparam int DOT_W   = 38;   // signed dv . d
	localparam int DOTM_W  = 37;   // |dv . d|
	localparam int PROD_W  = 40;   // multiplier result
	localparam int D2_W    = 41;   // |d|^2
	localparam int TR2_W   = 34;   // (2r)^2
	localparam int NUM_W   = 57;   // |d_axis| * |dot|
	localparam int QUO_W   = 17;   // quotient magnitude
	localparam int CH_W    = 18;   // signed velocity change
	localparam int NV_W    = 19;   // velocity before saturation

	localparam int PIXEL   = 256;

	localparam int MAX_NUDGES_DEF = 64;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd2560;
	localparam logic [POS_W-1:0] LEFT_RST   = 20'd0;
	localparam logic [POS_W-1:0] RIGHT_RST  = 20'd204800;
	localparam logic [POS_W-1:0] UPPER_RST  = 20'd0;
	localparam logic [POS_W-1:0] LOWER_RST  = 20'd102400;

	// register indexes; byte address is 4 * index
	typedef enum logic [2:0] {
		REG_RADIUS = 3'd0,
		REG_LEFT   = 3'd1,
		REG_RIGHT  = 3'd2,
		REG_UPPER  = 3'd3,
		REG_LOWER  = 3'd4
	} cfg_reg_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/dpcr_divider.sv]
// Restoring divider, one quotient bit per cycle, for the velocity change.
// Depends on dpcr_pkg. Quotient must be below 2**QUO_W.
module dpcr_divider import dpcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [D2_W-1:0]  den,
	output logic [QUO_W-1:0] quot,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D2_W-1:0]  rem_q;
	logic [QUO_W-1:0] sh_q;

	logic [D2_W:0] trial;
	logic [D2_W:0] diff;
	logic          ge;

	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= D2_W'(num[NUM_W-1:QUO_W]);
			sh_q  <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[D2_W-1:0] : trial[D2_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign quot      = sh_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/disc_pair_collision_resolve_core.sv]
// Disc pair collision core: equal-mass elastic impact plus separation pushes.
// An input transaction runs the impact phase, two 17-step divisions (skipped when the
// centers coincide), the velocity update and up to MAX_NUDGES pushes (states NDIF,
// NSQX, NSQY, NCMP per push), using the shared 20x20 multiplier and the divider; the
// next input is taken only after the result has been loaded into the output slot. Async
// active-low reset restores the register defaults and idles the sequencer; the output slot empties on reset.
`include "disc_pair_collision_resolve_core_assert.svh"

module disc_pair_collision_resolve_core import dpcr_pkg::*; #(
	parameter int unsigned MAX_NUDGES = MAX_NUDGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// low to high: first_x, first_y, first_vx, first_vy,
	//              second_x, second_y, second_vx, second_vy
	input  logic [DATA_W-1:0] s_axis_tdata,
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// low to high: new_first_x, new_first_y, new_first_vx, new_first_vy,
	//              new_second_x, new_second_y, new_second_vx, new_second_vy
	output logic [DATA_W-1:0] m_axis_tdata,
	// bit 0: still_overlapping
	output logic [0:0]        m_axis_tuser
);

	localparam int NW = $clog2(MAX_NUDGES + 1);

	// sequencer: impact phase, two divisions, velocity update, push loop
	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_DOTX = 19'h00002,
		S_DOTY = 19'h00004,
		S_SQX  = 19'h00008,
		S_SQY  = 19'h00010,
		S_TR   = 19'h00020,
		S_PXL  = 19'h00040,
		S_PXH  = 19'h00080,
		S_PYL  = 19'h00100,
		S_PYH  = 19'h00200,
		S_PEND = 19'h00400,
		S_DIVX = 19'h00800,
		S_DIVY = 19'h01000,
		S_VEL  = 19'h02000,
		S_NDIF = 19'h04000,
		S_NSQX = 19'h08000,
		S_NSQY = 19'h10000,
		S_NCMP = 19'h20000,
		S_DONE = 19'h40000
	} state_t;

	localparam logic signed [NV_W-1:0] VEL_MAX = 19'sd32767;
	localparam logic signed [NV_W-1:0] VEL_MIN = -19'sd32768;

	// ---------------------------------------------------------------- helpers
	function automatic logic [MAG_W-1:0] absdiff(input logic [POS_W-1:0] a,
	                                              input logic [POS_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [DVM_W-1:0] vel_abs(input logic signed [DVM_W:0] v);
		logic signed [DVM_W:0] n;
		n = -v;
		return v[DVM_W] ? n[DVM_W-1:0] : v[DVM_W-1:0];
	endfunction

	function automatic logic signed [DOT_W-1:0] sterm(input logic [35:0] m,
	                                                   input logic neg);
		logic signed [DOT_W-1:0] v;
		v = $signed({2'b00, m});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [CH_W-1:0] sgn_quot(input logic [QUO_W-1:0] q,
	                                                     input logic neg);
		logic signed [CH_W-1:0] v;
		v = $signed({1'b0, q});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [VEL_W-1:0] sat16(input logic signed [NV_W-1:0] v);
		if (v > VEL_MAX)
			return VEL_MAX[VEL_W-1:0];
		else if (v < VEL_MIN)
			return VEL_MIN[VEL_W-1:0];
		else
			return v[VEL_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] push_up(input logic [POS_W-1:0] v,
	                                              input logic [POS_W-1:0] hi);
		logic [POS_W:0] n;
		n = {1'b0, v} + (POS_W+1)'(PIXEL);
		return (n < {1'b0, hi}) ? n[POS_W-1:0] : hi;
	endfunction

	function automatic logic [POS_W-1:0] push_dn(input logic [POS_W-1:0] v,
	                                              input logic [POS_W-1:0] lo);
		logic [POS_W-1:0] n;
		n = v - POS_W'(PIXEL);
		if (v < POS_W'(PIXEL))
			return lo;
		else
			return (n > lo) ? n : lo;
	endfunction

	// ---------------------------------------------------------------- config
	logic [RAD_W-1:0] radius_q;
	logic [POS_W-1:0] left_q, right_q, upper_q, lower_q;
	cfg_reg_t         cfg_sel;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			left_q   <= LEFT_RST;
			right_q  <= RIGHT_RST;
			upper_q  <= UPPER_RST;
			lower_q  <= LOWER_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				REG_LEFT:   left_q   <= pwdata[POS_W-1:0];
				REG_RIGHT:  right_q  <= pwdata[POS_W-1:0];
				REG_UPPER:  upper_q  <= pwdata[POS_W-1:0];
				REG_LOWER:  lower_q  <= pwdata[POS_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_RADIUS: prdata = {16'd0, radius_q};
			REG_LEFT:   prdata = {12'd0, left_q};
			REG_RIGHT:  prdata = {12'd0, right_q};
			REG_UPPER:  prdata = {12'd0, upper_q};
			REG_LOWER:  prdata = {12'd0, lower_q};
			default:    prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------- datapath regs
	state_t state_q, state_d;

	logic [POS_W-1:0]        ax_q, ay_q, bx_q, by_q;      // positions, updated by pushes
	logic signed [VEL_W-1:0] avx_q, avy_q, bvx_q, bvy_q;  // velocities, updated once
	logic [MAG_W-1:0]        dxa_q, dya_q;                 // |dx|, |dy|
	logic                    sx_q, sy_q;                   // dx < 0, dy < 0
	logic [DVM_W-1:0]        dvxa_q, dvya_q;
	logic                    svx_q, svy_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [DOTM_W-1:0]       dotm_q;
	logic                    sdot_q;
	logic [D2_W-1:0]         d2_q;
	logic [TR2_W-1:0]        tr2_q;
	logic [NUM_W-1:0]        numx_q, numy_q;
	logic signed [CH_W-1:0]  chx_q, chy_q;
	logic [PROD_W-1:0]       sq_q;
	logic [PROD_W-1:0]       prod_q;
	logic [NW-1:0]           nudge_q;
	logic                    flag_q;

	logic [DATA_W-1:0] out_data_q;
	logic              out_user_q;
	logic              m_valid_q;

	logic in_acc;
	logic out_load;
	logic touch;
	logic at_limit;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
	assign touch         = ({1'b0, sq_q} + {1'b0, prod_q}) <= D2_W'(tr2_q);
	assign at_limit      = (nudge_q == NW'(MAX_NUDGES));

	// ---------------------------------------------------------------- shared multiplier
	logic [MAG_W-1:0] mul_a, mul_b;
	logic [16:0]      two_r;

	assign two_r = {radius_q, 1'b0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DOTX: begin mul_a = dxa_q; mul_b = MAG_W'(dvxa_q); end
			S_DOTY: begin mul_a = dya_q; mul_b = MAG_W'(dvya_q); end
			S_SQX, S_NSQX: begin mul_a = dxa_q; mul_b = dxa_q; end
			S_SQY, S_NSQY: begin mul_a = dya_q; mul_b = dya_q; end
			S_TR:   begin mul_a = MAG_W'(two_r); mul_b = MAG_W'(two_r); end
			S_PXL:  begin mul_a = dxa_q; mul_b = dotm_q[19:0]; end
			S_PXH:  begin mul_a = dxa_q; mul_b = MAG_W'(dotm_q[DOTM_W-1:20]); end
			S_PYL:  begin mul_a = dya_q; mul_b = dotm_q[19:0]; end
			S_PYH:  begin mul_a = dya_q; mul_b = MAG_W'(dotm_q[DOTM_W-1:20]); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ---------------------------------------------------------------- shared divider
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [QUO_W-1:0] div_quot;
	div_stat_t        div_st;

	assign div_start = ((state_q == S_PEND) && (d2_q != '0)) ||
	                   ((state_q == S_DIVX) && div_st.done);
	assign div_num   = (state_q == S_PEND) ? numx_q : numy_q;

	dpcr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d2_q),
		.quot   (div_quot),
		.stat   (div_st)
	);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_d = S_DOTX;
			S_DOTX: state_d = S_DOTY;
			S_DOTY: state_d = S_SQX;
			S_SQX:  state_d = S_SQY;
			S_SQY:  state_d = S_TR;
			S_TR:   state_d = S_PXL;
			S_PXL:  state_d = S_PXH;
			S_PXH:  state_d = S_PYL;
			S_PYL:  state_d = S_PYH;
			S_PYH:  state_d = S_PEND;
			S_PEND: state_d = (d2_q != '0) ? S_DIVX : S_VEL;
			S_DIVX: if (div_st.done) state_d = S_DIVY;
			S_DIVY: if (div_st.done) state_d = S_VEL;
			S_VEL:  state_d = S_NSQX;
			S_NDIF: state_d = S_NSQX;
			S_NSQX: state_d = S_NSQY;
			S_NSQY: state_d = S_NCMP;
			S_NCMP: state_d = (!touch || at_limit) ? S_DONE : S_NDIF;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nudge_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc)
				nudge_q <= '0;
			else if ((state_q == S_NCMP) && touch && !at_limit)
				nudge_q <= nudge_q + 1'b1;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath
	logic [POS_W-1:0]        in_ax, in_ay, in_bx, in_by;
	logic signed [VEL_W-1:0] in_avx, in_avy, in_bvx, in_bvy;
	logic signed [DVM_W:0]   in_dvx, in_dvy;
	logic [DOT_W-1:0]        dot_abs;
	logic                    ax_gt, ay_gt;

	assign in_ax  = s_axis_tdata[19:0];
	assign in_ay  = s_axis_tdata[39:20];
	assign in_avx = s_axis_tdata[55:40];
	assign in_avy = s_axis_tdata[71:56];
	assign in_bx  = s_axis_tdata[91:72];
	assign in_by  = s_axis_tdata[111:92];
	assign in_bvx = s_axis_tdata[127:112];
	assign in_bvy = s_axis_tdata[143:128];

	assign in_dvx  = (DVM_W+1)'(in_avx) - (DVM_W+1)'(in_bvx);
	assign in_dvy  = (DVM_W+1)'(in_avy) - (DVM_W+1)'(in_bvy);
	assign dot_abs = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
	// equal coordinates: first disc goes toward smaller values
	assign ax_gt   = ax_q > bx_q;
	assign ay_gt   = ay_q > by_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				ax_q   <= in_ax;
				ay_q   <= in_ay;
				bx_q   <= in_bx;
				by_q   <= in_by;
				avx_q  <= in_avx;
				avy_q  <= in_avy;
				bvx_q  <= in_bvx;
				bvy_q  <= in_bvy;
				dxa_q  <= absdiff(in_ax, in_bx);
				dya_q  <= absdiff(in_ay, in_by);
				sx_q   <= in_ax < in_bx;
				sy_q   <= in_ay < in_by;
				dvxa_q <= vel_abs(in_dvx);
				dvya_q <= vel_abs(in_dvy);
				svx_q  <= in_dvx[DVM_W];
				svy_q  <= in_dvy[DVM_W];
				flag_q <= 1'b0;
			end
			// each state consumes the product issued in the state before it
			S_DOTY: dot_q <= sterm(prod_q[35:0], sx_q ^ svx_q);
			S_SQX:  dot_q <= dot_q + sterm(prod_q[35:0], sy_q ^ svy_q);
			S_SQY: begin
				d2_q   <= D2_W'(prod_q);
				dotm_q <= dot_abs[DOTM_W-1:0];
				sdot_q <= dot_q[DOT_W-1];
			end
			S_TR:   d2_q   <= d2_q + D2_W'(prod_q);
			S_PXL:  tr2_q  <= prod_q[TR2_W-1:0];
			S_PXH:  numx_q <= NUM_W'(prod_q);
			S_PYL:  numx_q <= numx_q + {prod_q[NUM_W-21:0], 20'd0};
			S_PYH:  numy_q <= NUM_W'(prod_q);
			S_PEND: begin
				numy_q <= numy_q + {prod_q[NUM_W-21:0], 20'd0};
				// coincident centers: velocities pass unchanged
				if (d2_q == '0) begin
					chx_q <= '0;
					chy_q <= '0;
				end
			end
			S_DIVX: if (div_st.done) chx_q <= sgn_quot(div_quot, sx_q ^ sdot_q);
			S_DIVY: if (div_st.done) chy_q <= sgn_quot(div_quot, sy_q ^ sdot_q);
			S_VEL: begin
				avx_q <= sat16(NV_W'(avx_q) - NV_W'(chx_q));
				avy_q <= sat16(NV_W'(avy_q) - NV_W'(chy_q));
				bvx_q <= sat16(NV_W'(bvx_q) + NV_W'(chx_q));
				bvy_q <= sat16(NV_W'(bvy_q) + NV_W'(chy_q));
			end
			S_NDIF: begin
				dxa_q <= absdiff(ax_q, bx_q);
				dya_q <= absdiff(ay_q, by_q);
			end
			S_NSQY: sq_q <= prod_q;
			S_NCMP: if (touch) begin
				if (at_limit) begin
					flag_q <= 1'b1;
				end else begin
					ax_q <= ax_gt ? push_up(ax_q, right_q) : push_dn(ax_q, left_q);
					bx_q <= ax_gt ? push_dn(bx_q, left_q)  : push_up(bx_q, right_q);
					ay_q <= ay_gt ? push_up(ay_q, lower_q) : push_dn(ay_q, upper_q);
					by_q <= ay_gt ? push_dn(by_q, upper_q) : push_up(by_q, lower_q);
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output slot
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {bvy_q, bvx_q, by_q, bx_q, avy_q, avx_q, ay_q, ax_q};
			out_user_q <= flag_q;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;

	// ---------------------------------------------------------------- checks
	`DPCR_ASSERT_ALWAYS(a_div_in_phase, !div_st.busy || state_q == S_DIVX || state_q == S_DIVY, "divider busy outside division phase")
	`DPCR_ASSERT_ALWAYS(a_nudge_bound, nudge_q <= NW'(MAX_NUDGES), "push count beyond limit")
	`DPCR_ASSERT_ALWAYS(a_flag_at_limit, !(state_q == S_DONE && flag_q) || at_limit, "overlap flag without reaching push limit")
	`DPCR_ASSERT_NEXT(a_accept_starts, in_acc, state_q == S_DOTX && nudge_q == '0, "input transaction did not start the sequence")

endmodule
